// File: design/assert_macros.svh
// assertion macros included by complex_number_alu_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cna_pkg.sv
// command and status codes for the complex number alu
package cna_pkg;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_DIST = 3'd4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

endpackage

// File: design/complex_number_alu_core.sv
// complex number alu: add, subtract, multiply, divide and distance in signed fixed point
//
// Usage:
//   Request channel: in_valid / in_stall with command and the two complex operands
//   a_real, a_imag, b_real, b_imag. Result channel: out_valid / out_stall with
//   result_real, result_imag and status (ok, divide by zero, saturated).
//   One result leaves for every request, in request order.
//   From acceptance to out_valid a request passes through these stages:
//   five set-up stages (operand capture, products, sums, magnitudes, divider set-up),
//   DATA_WIDTH + 1 stages of the restoring divider and square root, each retiring one
//   quotient bit and one root bit, and the rounding and output register.
//   Throughput is one request per cycle when not stalled; the pipeline has no loop back.
//   When out_stall is held while a result waits, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   Rounding is to nearest with ties away from zero on the magnitude; add and
//   subtract are exact before saturation.
module complex_number_alu_core #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   command,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] result_real,
    output logic signed [DATA_WIDTH-1:0] result_imag,
    output cna_pkg::status_t             status
);
    import cna_pkg::*;

`include "assert_macros.svh"

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int W1   = W + 1;
    localparam int PW   = 2 * W;
    localparam int SW   = 2 * W + 1;
    localparam int SQ   = 2 * W + 2;
    localparam int MW   = 2 * W;
    localparam int QB   = W + 1;
    localparam int QW   = W + 2;
    localparam int XW   = 3 * W + F + 1;
    localparam int L    = W + 1;
    localparam int RW   = 2 * W + 1;
    localparam int SQW  = RW + 1;
    localparam int MAGW = SW + 1;
    localparam int HALF_I = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;

    // largest and smallest result values
    localparam logic [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};

    // magnitude of a two's complement value, read as unsigned
    function automatic logic [W:0] abs_n(input logic [W:0] v);
        return v[W] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [SW-1:0] abs_w(input logic [SW-1:0] v);
        return v[SW-1] ? (~v + 1'b1) : v;
    endfunction

    // saturate sign and magnitude to W bits, top bit of result is the overflow flag
    function automatic logic [W:0] sat_fn(input logic neg, input logic [MAGW-1:0] mag);
        logic [MAGW-1:0] lim;
        logic [MAGW-1:0] nm;
        logic [W:0]      r;
        lim = MAGW'(1) << (W - 1);
        nm  = ~mag + MAGW'(1);
        if (neg)
        begin
            if (mag > lim)
                r = {1'b1, lim[W-1:0]};
            else
                r = {1'b0, nm[W-1:0]};
        end
        else
        begin
            if (mag > lim - MAGW'(1))
                r = {1'b1, lim[W-1:0] - W'(1)};
            else
                r = {1'b0, mag[W-1:0]};
        end
        return r;
    endfunction

    logic en;

    // pipeline advances unless a finished result is held back
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // stage a: capture operands, sums and differences
    logic                 a_v_reg;
    logic [2:0]           a_cmd_reg;
    logic signed [W-1:0]  a_ar_reg, a_ai_reg, a_br_reg, a_bi_reg;
    logic signed [W1-1:0] a_xr_reg, a_xi_reg, a_dr_reg, a_di_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (en)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cmd_reg <= command;
            a_ar_reg  <= a_real;
            a_ai_reg  <= a_imag;
            a_br_reg  <= b_real;
            a_bi_reg  <= b_imag;
            a_dr_reg  <= W1'(a_real) - W1'(b_real);
            a_di_reg  <= W1'(a_imag) - W1'(b_imag);
            if (command == CMD_SUB)
            begin
                a_xr_reg <= W1'(a_real) - W1'(b_real);
                a_xi_reg <= W1'(a_imag) - W1'(b_imag);
            end
            else
            begin
                a_xr_reg <= W1'(a_real) + W1'(b_real);
                a_xi_reg <= W1'(a_imag) + W1'(b_imag);
            end
        end
    end

    // stage b: six multipliers, squares shared between divisor and distance
    logic                 b_v_reg;
    logic [2:0]           b_cmd_reg;
    logic signed [PW-1:0] b_prr_reg, b_pii_reg, b_pri_reg, b_pir_reg;
    logic signed [SQ-1:0] b_s5_reg, b_s6_reg;
    logic                 b_big_reg;
    logic [W:0]           b_asr_reg, b_asi_reg;
    logic signed [W1-1:0] op5, op6;
    logic [W:0]           abs_dr, abs_di, abs_xr, abs_xi;

    always_comb
    begin
        op5    = (a_cmd_reg == CMD_DIST) ? a_dr_reg : W1'(a_br_reg);
        op6    = (a_cmd_reg == CMD_DIST) ? a_di_reg : W1'(a_bi_reg);
        abs_dr = abs_n(a_dr_reg);
        abs_di = abs_n(a_di_reg);
        abs_xr = abs_n(a_xr_reg);
        abs_xi = abs_n(a_xi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_cmd_reg <= a_cmd_reg;
            b_prr_reg <= PW'(a_ar_reg) * PW'(a_br_reg);
            b_pii_reg <= PW'(a_ai_reg) * PW'(a_bi_reg);
            b_pri_reg <= PW'(a_ar_reg) * PW'(a_bi_reg);
            b_pir_reg <= PW'(a_ai_reg) * PW'(a_br_reg);
            b_s5_reg  <= SQ'(op5) * SQ'(op5);
            b_s6_reg  <= SQ'(op6) * SQ'(op6);
            b_big_reg <= (abs_dr >= (W1'(1) << (W - 1))) || (abs_di >= (W1'(1) << (W - 1)));
            b_asr_reg <= sat_fn(a_xr_reg[W], MAGW'(abs_xr));
            b_asi_reg <= sat_fn(a_xi_reg[W], MAGW'(abs_xi));
        end
    end

    // stage c: sums of products
    logic                 c_v_reg;
    logic [2:0]           c_cmd_reg;
    logic signed [SW-1:0] c_pr_reg, c_pi_reg, c_nr_reg, c_ni_reg;
    logic [SQ-1:0]        c_sq_reg;
    logic                 c_big_reg;
    logic [W:0]           c_asr_reg, c_asi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (en)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_cmd_reg <= b_cmd_reg;
            c_pr_reg  <= SW'(b_prr_reg) - SW'(b_pii_reg);
            c_pi_reg  <= SW'(b_pri_reg) + SW'(b_pir_reg);
            c_nr_reg  <= SW'(b_prr_reg) + SW'(b_pii_reg);
            c_ni_reg  <= SW'(b_pir_reg) - SW'(b_pri_reg);
            c_sq_reg  <= b_s5_reg[SQ-1:0] + b_s6_reg[SQ-1:0];
            c_big_reg <= b_big_reg;
            c_asr_reg <= b_asr_reg;
            c_asi_reg <= b_asi_reg;
        end
    end

    // stage d: sign and magnitude split
    logic                 d_v_reg;
    logic [2:0]           d_cmd_reg;
    logic                 d_npr_reg, d_npi_reg, d_nnr_reg, d_nni_reg;
    logic [SW-1:0]        d_mpr_reg, d_mpi_reg, d_mnr_reg, d_mni_reg;
    logic [MW-1:0]        d_d_reg;
    logic                 d_dz_reg;
    logic [RW-1:0]        d_x_reg;
    logic                 d_big_reg;
    logic [W:0]           d_asr_reg, d_asi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (en)
            d_v_reg <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_cmd_reg <= c_cmd_reg;
            d_npr_reg <= c_pr_reg[SW-1];
            d_npi_reg <= c_pi_reg[SW-1];
            d_nnr_reg <= c_nr_reg[SW-1];
            d_nni_reg <= c_ni_reg[SW-1];
            d_mpr_reg <= abs_w(c_pr_reg);
            d_mpi_reg <= abs_w(c_pi_reg);
            d_mnr_reg <= abs_w(c_nr_reg);
            d_mni_reg <= abs_w(c_ni_reg);
            d_d_reg   <= c_sq_reg[MW-1:0];
            d_dz_reg  <= (c_sq_reg == '0);
            d_x_reg   <= c_sq_reg[RW-1:0];
            d_big_reg <= c_big_reg;
            d_asr_reg <= c_asr_reg;
            d_asi_reg <= c_asi_reg;
        end
    end

    // iteration stages; index 0 is the divider set-up stage
    logic           it_v_reg   [0:L];
    logic [2:0]     it_cmd_reg [0:L];
    logic           it_dz_reg  [0:L];
    logic           it_big_reg [0:L];
    logic [W:0]     it_pr_reg  [0:L];
    logic [W:0]     it_pi_reg  [0:L];
    logic           it_nr_reg  [0:L];
    logic           it_ni_reg  [0:L];
    logic           it_or_reg  [0:L];
    logic           it_oi_reg  [0:L];
    logic [MW-1:0]  it_d_reg   [0:L];
    logic [XW-1:0]  it_rr_reg  [0:L];
    logic [XW-1:0]  it_ri_reg  [0:L];
    logic [QB-1:0]  it_qr_reg  [0:L];
    logic [QB-1:0]  it_qi_reg  [0:L];
    logic [SQW-1:0] it_sx_reg  [0:L];
    logic [SQW-1:0] it_sr_reg  [0:L];

    // stage e: multiply rounding, pre-selected result, divider start values
    logic [W:0]    mul_r, mul_i, pre_r, pre_i;
    logic [XW-1:0] num_r, num_i, den_sh;

    always_comb
    begin
        mul_r  = sat_fn(d_npr_reg, (MAGW'(d_mpr_reg) + MAGW'(HALF_I)) >> F);
        mul_i  = sat_fn(d_npi_reg, (MAGW'(d_mpi_reg) + MAGW'(HALF_I)) >> F);
        num_r  = XW'(d_mnr_reg) << F;
        num_i  = XW'(d_mni_reg) << F;
        den_sh = XW'(d_d_reg) << QB;
        case (d_cmd_reg) inside
            CMD_ADD, CMD_SUB:
            begin
                pre_r = d_asr_reg;
                pre_i = d_asi_reg;
            end
            CMD_MUL:
            begin
                pre_r = mul_r;
                pre_i = mul_i;
            end
            default:
            begin
                pre_r = '0;
                pre_i = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            it_v_reg[0] <= 1'b0;
        else if (en)
            it_v_reg[0] <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_cmd_reg[0] <= d_cmd_reg;
            it_dz_reg[0]  <= d_dz_reg;
            it_big_reg[0] <= d_big_reg;
            it_pr_reg[0]  <= pre_r;
            it_pi_reg[0]  <= pre_i;
            it_nr_reg[0]  <= d_nnr_reg;
            it_ni_reg[0]  <= d_nni_reg;
            it_or_reg[0]  <= (num_r >= den_sh);
            it_oi_reg[0]  <= (num_i >= den_sh);
            it_d_reg[0]   <= d_d_reg;
            it_rr_reg[0]  <= num_r;
            it_ri_reg[0]  <= num_i;
            it_qr_reg[0]  <= '0;
            it_qi_reg[0]  <= '0;
            it_sx_reg[0]  <= SQW'(d_x_reg);
            it_sr_reg[0]  <= '0;
        end
    end

    // one quotient bit per divider and one root bit per stage
    for (genvar k = 0; k < L; k++)
    begin : g_iter
        logic [XW-1:0]  dk;
        logic [SQW-1:0] bitk, trial;
        logic           take_r, take_i, take_s;

        always_comb
        begin
            dk     = XW'(it_d_reg[k]) << (QB - 1 - k);
            bitk   = SQW'(1) << (2 * (L - 1 - k));
            trial  = it_sr_reg[k] + bitk;
            take_r = (it_rr_reg[k] >= dk);
            take_i = (it_ri_reg[k] >= dk);
            take_s = (it_sx_reg[k] >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                it_v_reg[k+1] <= 1'b0;
            else if (en)
                it_v_reg[k+1] <= it_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_cmd_reg[k+1] <= it_cmd_reg[k];
                it_dz_reg[k+1]  <= it_dz_reg[k];
                it_big_reg[k+1] <= it_big_reg[k];
                it_pr_reg[k+1]  <= it_pr_reg[k];
                it_pi_reg[k+1]  <= it_pi_reg[k];
                it_nr_reg[k+1]  <= it_nr_reg[k];
                it_ni_reg[k+1]  <= it_ni_reg[k];
                it_or_reg[k+1]  <= it_or_reg[k];
                it_oi_reg[k+1]  <= it_oi_reg[k];
                it_d_reg[k+1]   <= it_d_reg[k];
                it_rr_reg[k+1]  <= take_r ? (it_rr_reg[k] - dk) : it_rr_reg[k];
                it_ri_reg[k+1]  <= take_i ? (it_ri_reg[k] - dk) : it_ri_reg[k];
                it_qr_reg[k+1]  <= {it_qr_reg[k][QB-2:0], take_r};
                it_qi_reg[k+1]  <= {it_qi_reg[k][QB-2:0], take_i};
                it_sx_reg[k+1]  <= take_s ? (it_sx_reg[k] - trial) : it_sx_reg[k];
                it_sr_reg[k+1]  <= take_s ? ((it_sr_reg[k] >> 1) + bitk) : (it_sr_reg[k] >> 1);
            end
        end
    end

    // final rounding, saturation and result selection
    logic [XW-1:0]   dext;
    logic [QW-1:0]   qf_r, qf_i;
    logic [MAGW-1:0] dm_r, dm_i;
    logic [SQW-1:0]  root;
    logic [W:0]      div_r, div_i, dist_r, fin_r, fin_i;
    status_t         fin_st;

    always_comb
    begin
        dext   = XW'(it_d_reg[L]);
        qf_r   = QW'(it_qr_reg[L]) + QW'(it_rr_reg[L] >= dext - it_rr_reg[L]);
        qf_i   = QW'(it_qi_reg[L]) + QW'(it_ri_reg[L] >= dext - it_ri_reg[L]);
        dm_r   = it_or_reg[L] ? {MAGW{1'b1}} : MAGW'(qf_r);
        dm_i   = it_oi_reg[L] ? {MAGW{1'b1}} : MAGW'(qf_i);
        div_r  = sat_fn(it_nr_reg[L], dm_r);
        div_i  = sat_fn(it_ni_reg[L], dm_i);
        root   = it_sr_reg[L] + SQW'(it_sx_reg[L] > it_sr_reg[L]);
        dist_r = it_big_reg[L] ? sat_fn(1'b0, MAGW'(1) << (W - 1))
                               : sat_fn(1'b0, MAGW'(root));
        case (it_cmd_reg[L])
            CMD_DIV:
            begin
                fin_r = it_dz_reg[L] ? '0 : div_r;
                fin_i = it_dz_reg[L] ? '0 : div_i;
            end
            CMD_DIST:
            begin
                fin_r = dist_r;
                fin_i = '0;
            end
            default:
            begin
                fin_r = it_pr_reg[L];
                fin_i = it_pi_reg[L];
            end
        endcase
        if (it_cmd_reg[L] == CMD_DIV && it_dz_reg[L])
            fin_st = ST_DIV0;
        else if (fin_r[W] || fin_i[W])
            fin_st = ST_SAT;
        else
            fin_st = ST_OK;
    end

    // output register
    logic                out_v_reg;
    logic [2:0]          out_cmd_reg;
    logic signed [W-1:0] out_r_reg, out_i_reg;
    status_t             out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= it_v_reg[L];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_cmd_reg <= it_cmd_reg[L];
            out_r_reg   <= fin_r[W-1:0];
            out_i_reg   <= fin_i[W-1:0];
            out_st_reg  <= fin_st;
        end
    end

    assign out_valid   = out_v_reg;
    assign result_real = out_r_reg;
    assign result_imag = out_i_reg;
    assign status      = out_st_reg;

    // checks
    `ASSERT_SAME(a_div0_zero, out_valid && status == ST_DIV0, result_real == '0 && result_imag == '0, "divide by zero with nonzero result")
    `ASSERT_SAME(a_dist_pos, out_valid && out_cmd_reg == CMD_DIST, !result_real[W-1] && result_imag == '0, "distance negative or imaginary part set")
    `ASSERT_SAME(a_sat_edge, out_valid && status == ST_SAT, result_real == SAT_HI || result_real == SAT_LO || result_imag == SAT_HI || result_imag == SAT_LO, "saturation flagged without a limit value")

endmodule
